// File: rtl/lgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

  // Item command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Register indexes on the APB port (paddr bit 2)
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Neighbour counts of the rule
  localparam logic [3:0] NB_KEEP  = 4'd2;
  localparam logic [3:0] NB_BIRTH = 4'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_rd;        // read the row of a load word
    logic load_wr;        // write the modified row back
    logic read_rd;        // read the row of a read word
    logic out_load;       // capture the read cell into the output register
    logic step_rd_last;   // step: read the last used row
    logic step_rd_first;  // step: read row 0, keep last row as previous
    logic step_prime;     // step: keep row 0, start the row counter
    logic step_row;       // step: compute and write one row
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_row;       // the row in hand is the last used row
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/lgs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module lgs_cfg #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic [$clog2(((MAX_COLS < 64) ? MAX_COLS : 64) + 1)-1:0] cols_used,
  output logic [$clog2(MAX_ROWS + 1)-1:0]          rows_used
);

  localparam int COLS = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int CWW  = $clog2(COLS + 1);
  localparam int HW   = $clog2(MAX_ROWS + 1);
  localparam int CMPW = (HW > 7) ? HW : 7;

  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic [CMPW-1:0] h_wide;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        lgs_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[6:0];
        lgs_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[2])
      lgs_pkg::REG_GRID_WIDTH:  prdata = {25'd0, grid_width};
      lgs_pkg::REG_GRID_HEIGHT: prdata = {25'd0, grid_height};
      default:                  prdata = '0;
    endcase
  end

  // clamp sizes: zero counts as one, above the physical grid counts as its size
  always_comb begin
    if (grid_width == 7'd0)
      cols_used = CWW'(1);
    else if (grid_width > 7'(COLS))
      cols_used = CWW'(COLS);
    else
      cols_used = CWW'(grid_width);
  end

  assign h_wide = CMPW'(grid_height);

  always_comb begin
    if (h_wide == '0)
      rows_used = HW'(1);
    else if (h_wide > CMPW'(MAX_ROWS))
      rows_used = HW'(MAX_ROWS);
    else
      rows_used = HW'(h_wide);
  end

endmodule

`default_nettype wire

// File: rtl/lgs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lgs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        cmd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lgs_pkg::dp_cmd_t       dpc,
  input  wire lgs_pkg::dp_stat_t dps
);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_STEP_FIRST = 3'd1;
  localparam logic [2:0] ST_STEP_PRIME = 3'd2;
  localparam logic [2:0] ST_STEP_RUN   = 3'd3;
  localparam logic [2:0] ST_LOAD_WR    = 3'd4;
  localparam logic [2:0] ST_READ_WAIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    dpc            = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            lgs_pkg::CMD_LOAD: begin
              dpc.load_rd = 1'b1;
              state_next  = ST_LOAD_WR;
            end
            lgs_pkg::CMD_STEP: begin
              dpc.step_rd_last = 1'b1;
              state_next       = ST_STEP_FIRST;
            end
            lgs_pkg::CMD_READ: begin
              dpc.read_rd = 1'b1;
              state_next  = ST_READ_WAIT;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      ST_STEP_FIRST: begin
        dpc.step_rd_first = 1'b1;
        state_next        = ST_STEP_PRIME;
      end
      ST_STEP_PRIME: begin
        dpc.step_prime = 1'b1;
        state_next     = ST_STEP_RUN;
      end
      ST_STEP_RUN: begin
        dpc.step_row = 1'b1;
        if (dps.last_row) state_next = ST_IDLE;
      end
      ST_LOAD_WR: begin
        dpc.load_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_READ_WAIT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          dpc.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a step sweep ends on its last row
  a_step_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP_RUN) && dps.last_row |=> (state == ST_IDLE))
    else $error("step sweep did not return to idle after last row");

  // a read word always enters the read wait state
  a_read_out: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == lgs_pkg::CMD_READ) |=> (state == ST_READ_WAIT))
    else $error("read word did not enter read wait");

  a_out_once: assert property (@(posedge clk) disable iff (rst)
    dpc.out_load |=> out_valid)
    else $error("output load did not raise out_valid");

endmodule

`default_nettype wire

// File: rtl/lgs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lgs_dp #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lgs_pkg::dp_cmd_t                  dpc,
  output lgs_pkg::dp_stat_t                      dps,
  input  wire logic [5:0]                        row,
  input  wire logic [5:0]                        col,
  input  wire logic                              alive_in,
  input  wire logic [$clog2(((MAX_COLS < 64) ? MAX_COLS : 64) + 1)-1:0] cols_used,
  input  wire logic [$clog2(MAX_ROWS + 1)-1:0]   rows_used,
  output logic                                   alive_out
);

  localparam int COLS = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int CWW  = $clog2(COLS + 1);
  localparam int CIW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int HW   = $clog2(MAX_ROWS + 1);
  localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // row store with one flag per row; a row without its flag reads as dead
  logic [COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_ok;
  logic [COLS-1:0] rdata;
  logic            rdata_ok;
  logic [COLS-1:0] eff_row;

  logic            re;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [COLS-1:0] wdata;

  // sweep state
  logic [COLS-1:0] first_row;
  logic [COLS-1:0] prev_row;
  logic [COLS-1:0] here_row;
  logic [COLS-1:0] below_row;
  logic [COLS-1:0] new_row;
  logic [AW-1:0]   r;
  logic            ahead_ok;
  logic            clear_tail;

  // captured item
  logic [AW-1:0]   item_addr;
  logic [CIW-1:0]  item_col;
  logic            item_alive;
  logic            item_in;
  logic [COLS-1:0] ld_word;
  logic [CIW-1:0]  wm1;

  assign eff_row  = rdata_ok ? rdata : '0;
  assign dps.last_row = (HW'(r) + HW'(1) == rows_used);
  assign ahead_ok = ((HW + 1)'(r) + (HW + 1)'(2)) < (HW + 1)'(rows_used);
  assign clear_tail = dpc.step_row && dps.last_row;
  assign below_row = dps.last_row ? first_row : eff_row;

  // read port address
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (dpc.load_rd || dpc.read_rd) begin
      re    = 1'b1;
      raddr = AW'(row);
    end else if (dpc.step_rd_last) begin
      re    = 1'b1;
      raddr = AW'(rows_used - HW'(1));
    end else if (dpc.step_rd_first) begin
      re    = 1'b1;
      raddr = '0;
    end else if (dpc.step_prime) begin
      re    = (rows_used > HW'(1));
      raddr = AW'(1);
    end else if (dpc.step_row) begin
      re    = ahead_ok;
      raddr = r + AW'(2);
    end
  end

  // load: modify one bit of the row read
  always_comb begin
    ld_word = eff_row;
    ld_word[item_col] = item_alive;
  end

  assign we    = dpc.step_row || (dpc.load_wr && item_in);
  assign waddr = dpc.step_row ? r : item_addr;
  assign wdata = dpc.step_row ? new_row : ld_word;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata    <= mem[raddr];
      rdata_ok <= row_ok[raddr];
    end
  end

  // row flags: reset clears all, a write sets one, step end clears unused rows
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        if (clear_tail && ((HW + 1)'(i) >= (HW + 1)'(rows_used))) row_ok[i] <= 1'b0;
        if (we && (waddr == AW'(i))) row_ok[i] <= 1'b1;
      end
    end
  end

  // next generation of one row, one cell per column
  assign wm1 = CIW'(cols_used - CWW'(1));

  for (genvar c = 0; c < COLS; c++) begin : g_col
    logic [CIW-1:0] lft;
    logic [CIW-1:0] rgt;
    logic [3:0]     n;
    assign lft = (c == 0) ? wm1 : CIW'((c + COLS - 1) % COLS);
    assign rgt = (CWW'(c + 1) == cols_used) ? '0 : CIW'((c + 1) % COLS);
    assign n = 4'(prev_row[lft]) + 4'(prev_row[c]) + 4'(prev_row[rgt])
             + 4'(here_row[lft]) + 4'(here_row[rgt])
             + 4'(below_row[lft]) + 4'(below_row[c]) + 4'(below_row[rgt]);
    assign new_row[c] = (CWW'(c) < cols_used) &&
                        ((n == lgs_pkg::NB_BIRTH) || ((n == lgs_pkg::NB_KEEP) && here_row[c]));
  end

  // sweep registers
  always_ff @(posedge clk) begin
    if (dpc.step_rd_first) prev_row <= eff_row;
    if (dpc.step_prime) begin
      first_row <= eff_row;
      here_row  <= eff_row;
      r         <= '0;
    end
    if (dpc.step_row) begin
      prev_row <= here_row;
      here_row <= below_row;
      r        <= r + AW'(1);
    end
  end

  // item capture and output register
  always_ff @(posedge clk) begin
    if (dpc.load_rd || dpc.read_rd) begin
      item_addr  <= AW'(row);
      item_col   <= col[CIW-1:0];
      item_alive <= alive_in;
      item_in    <= (11'(row) < 11'(MAX_ROWS)) && ({1'b0, col} < 7'(COLS));
    end
    if (dpc.out_load) alive_out <= item_in && eff_row[item_col];
  end

  // the look-ahead read never hits the row being written
  a_no_clash: assert property (@(posedge clk) disable iff (rst)
    dpc.step_row && re |-> (raddr != waddr))
    else $error("step read and write on the same row");

  // row 0 is always rewritten by a step
  a_row0_ok: assert property (@(posedge clk) disable iff (rst)
    clear_tail |=> row_ok[0])
    else $error("row 0 not valid after step");

endmodule

`default_nettype wire

// File: rtl/life_generation_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Load: a read-modify-write; the next word is taken after the write-back state.
// Read: the row is read on acceptance; alive_out is loaded once the output register is free,
//   and the next word is taken after the read wait state.
// Step: one row per cycle through the single read port and the row update logic, after
//   reading the last row and row 0.
// Reset (rst, synchronous): all cells dead through per-row flags at once, sizes 64 x 64.
module life_generation_step #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [5:0]  row,
  input  wire logic [5:0]  col,
  input  wire logic        alive_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             alive_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int COLS = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int CWW  = $clog2(COLS + 1);
  localparam int HW   = $clog2(MAX_ROWS + 1);

  logic [CWW-1:0]    cols_used;
  logic [HW-1:0]     rows_used;
  lgs_pkg::dp_cmd_t  dpc;
  lgs_pkg::dp_stat_t dps;

  assign pready = 1'b1;

  lgs_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cols_used (cols_used),
    .rows_used (rows_used)
  );

  lgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dpc       (dpc),
    .dps       (dps)
  );

  lgs_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .dpc       (dpc),
    .dps       (dps),
    .row       (row),
    .col       (col),
    .alive_in  (alive_in),
    .cols_used (cols_used),
    .rows_used (rows_used),
    .alive_out (alive_out)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Command 3 has no name in the package: the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 235;
  localparam int PHASES          = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 80;    // longer than a 64-row step
  localparam int QUIET_LIMIT     = 4000;

  // Sizes per phase; phase 0 runs on the reset sizes
  localparam logic [6:0] PHASE_W [PHASES] = '{7'd64, 7'd0, 7'd2, 7'd1,
                                              7'd127, 7'd37, 7'd3, 7'd64};
  localparam logic [6:0] PHASE_H [PHASES] = '{7'd64, 7'd0, 7'd2, 7'd127,
                                              7'd1, 7'd5, 7'd64, 7'd3};

  // Directed stimulus; 'fixed' rows carry their read value typed in
  typedef struct packed {
    logic [1:0] op;
    logic [5:0] r;
    logic [5:0] c;
    logic       live;
    logic       fixed;
    logic       want;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{lgs_pkg::CMD_READ, 6'd0,  6'd0,  1'b0, 1'b1, 1'b0},  // empty after reset
    '{lgs_pkg::CMD_READ, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
    '{lgs_pkg::CMD_LOAD, 6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{lgs_pkg::CMD_LOAD, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
    '{lgs_pkg::CMD_READ, 6'd0,  6'd0,  1'b0, 1'b1, 1'b1},
    '{lgs_pkg::CMD_READ, 6'd63, 6'd63, 1'b0, 1'b1, 1'b1},
    '{CMD_UNUSED,        6'd63, 6'd63, 1'b0, 1'b0, 1'b0},  // must not touch the cell
    '{lgs_pkg::CMD_READ, 6'd63, 6'd63, 1'b0, 1'b1, 1'b1},
    '{lgs_pkg::CMD_LOAD, 6'd0,  6'd63, 1'b1, 1'b0, 1'b0},  // corners: block across wrap
    '{lgs_pkg::CMD_LOAD, 6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
    '{lgs_pkg::CMD_STEP, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_READ, 6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_READ, 6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_LOAD, 6'd10, 6'd9,  1'b1, 1'b0, 1'b0},  // blinker
    '{lgs_pkg::CMD_LOAD, 6'd10, 6'd10, 1'b1, 1'b0, 1'b0},
    '{lgs_pkg::CMD_LOAD, 6'd10, 6'd11, 1'b1, 1'b0, 1'b0},
    '{lgs_pkg::CMD_STEP, 6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{lgs_pkg::CMD_READ, 6'd9,  6'd10, 1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_READ, 6'd11, 6'd10, 1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_READ, 6'd10, 6'd9,  1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_LOAD, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_STEP, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_READ, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{lgs_pkg::CMD_READ, 6'd42, 6'd21, 1'b1, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = lgs_pkg::CMD_LOAD;
  logic [5:0]  row = '0;
  logic [5:0]  col = '0;
  logic        alive_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        alive_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [63:0] life_grid [64];
  logic [6:0]  cfg_width  = 7'd64;
  logic [6:0]  cfg_height = 7'd64;
  logic        read_cells_due [$];

  int send_gap_pct   = 0;
  int ready_drop_pct = 0;
  bit hold_req       = 1'b0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  life_generation_step u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .row      (row),
    .col      (col),
    .alive_in (alive_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .alive_out(alive_out),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < 64; i++) life_grid[i] = '0;
  end

  // Sizes as the block uses them: 0 counts as 1, anything above 64 as 64
  function automatic int cols_in_use();
    int w;
    w = cfg_width;
    if (w == 0) w = 1;
    if (w > 64) w = 64;
    return w;
  endfunction

  function automatic int rows_in_use();
    int h;
    h = cfg_height;
    if (h == 0) h = 1;
    if (h > 64) h = 64;
    return h;
  endfunction

  // One row of the next generation; wrapped repeats are counted each time
  function automatic logic [63:0] next_gen_row(logic [63:0] above, logic [63:0] here,
                                               logic [63:0] below, int w);
    logic [63:0] nxt;
    int left, right, nb;
    nxt = '0;
    for (int c = 0; c < w; c++) begin
      left  = (c == 0) ? w - 1 : c - 1;
      right = (c + 1 == w) ? 0 : c + 1;
      nb = int'(above[left]) + int'(above[c]) + int'(above[right])
         + int'(here[left]) + int'(here[right])
         + int'(below[left]) + int'(below[c]) + int'(below[right]);
      // two keeps the cell, three makes it live, anything else kills it
      if (nb == 2) nxt[c] = here[c];
      else nxt[c] = (nb == 3);
    end
    return nxt;
  endfunction

  // Whole-grid update; rows above and below are the pre-step values
  function automatic void advance_generation();
    logic [63:0] first, prev, here, below;
    int w, h;
    w = cols_in_use();
    h = rows_in_use();
    first = life_grid[0];
    prev  = life_grid[h - 1];
    for (int r = 0; r < h; r++) begin
      here  = life_grid[r];
      below = (r + 1 < h) ? life_grid[r + 1] : first;
      life_grid[r] = next_gen_row(prev, here, below, w);
      prev = here;
    end
    for (int r = h; r < 64; r++) life_grid[r] = '0;
  endfunction

  function automatic void apply_word(logic [1:0] op, logic [5:0] r, logic [5:0] c,
                                     logic live, logic fixed, logic want);
    case (op)
      lgs_pkg::CMD_LOAD: life_grid[r][c] = live;
      lgs_pkg::CMD_STEP: advance_generation();
      lgs_pkg::CMD_READ: read_cells_due.push_back(fixed ? want : life_grid[r][c]);
      default: ;
    endcase
  endfunction

  // Coordinates biased to the corners of the used area, where wrap matters
  function automatic logic [5:0] pick_coord(int n);
    int k, span;
    k = $urandom_range(9);
    span = (n < 6) ? n : 6;
    if (k < 4) return 6'($urandom_range(span - 1));
    if (k < 7) return 6'(n - 1 - $urandom_range(span - 1));
    if (k < 9) return 6'($urandom_range(n - 1));
    return 6'($urandom_range(63));
  endfunction

  // Offer one word, predict on acceptance, then maybe go idle
  task automatic offer_word(logic [1:0] op, logic [5:0] r, logic [5:0] c,
                            logic live, logic fixed, logic want);
    int gap;
    in_valid <= 1'b1;
    cmd      <= op;
    row      <= r;
    col      <= c;
    alive_in <= live;
    do @(posedge clk); while (!in_ready);
    apply_word(op, r, c, live, fixed, want);
    gap = 0;
    while (gap < 400 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_word();
    int pick;
    logic [1:0] op;
    pick = $urandom_range(99);
    if (pick < 45) op = lgs_pkg::CMD_LOAD;
    else if (pick < 78) op = lgs_pkg::CMD_READ;
    else if (pick < 96) op = lgs_pkg::CMD_STEP;
    else op = CMD_UNUSED;
    offer_word(op, pick_coord(rows_in_use()), pick_coord(cols_in_use()),
               $urandom_range(99) < 60, 1'b0, 1'b0);
  endtask

  // Let all reads return, then cover a step still in flight
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (read_cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access, then idle
  task automatic write_reg(logic idx, logic [6:0] val);
    logic [31:0] word;
    word = $urandom;
    word[6:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == lgs_pkg::REG_GRID_WIDTH) cfg_width = word[6:0];
    else cfg_height = word[6:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= ready_drop_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && out_ready) begin
      if (read_cells_due.size() == 0) begin
        $error("alive_out: result with no read outstanding, got %0d", alive_out);
        mismatches++;
      end else begin
        want = read_cells_due.pop_front();
        if (alive_out !== want) begin
          $error("alive_out mismatch: expected %0d, got %0d", want, alive_out);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL life_generation_step");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words on the reset sizes
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_word(DIRECTED[i].op, DIRECTED[i].r, DIRECTED[i].c, DIRECTED[i].live,
                 DIRECTED[i].fixed, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        write_reg(lgs_pkg::REG_GRID_WIDTH, PHASE_W[p]);
        write_reg(lgs_pkg::REG_GRID_HEIGHT, PHASE_H[p]);
      end
      case (p % 4)
        0: begin send_gap_pct = 0;  ready_drop_pct = 0;  end
        1: begin send_gap_pct = 86; ready_drop_pct = 0;  end
        2: begin send_gap_pct = 0;  ready_drop_pct = 86; end
        default: begin send_gap_pct = 23; ready_drop_pct = 23; end
      endcase
      // long receiver hold-off while reads keep coming, to back up the input
      if (p == 0) begin
        hold_req = 1'b1;
        repeat (40) offer_word(lgs_pkg::CMD_READ, pick_coord(rows_in_use()),
                               pick_coord(cols_in_use()), 1'($urandom), 1'b0, 1'b0);
      end
      repeat (ITEMS_PER_PHASE) send_random_word();
    end

    wait_drained();
    if (mismatches == 0 && read_cells_due.size() == 0) begin
      $display("PASS life_generation_step");
    end else begin
      $display("FAIL life_generation_step");
    end
    $finish;
  end

endmodule
